>>> rtl/gxlit_pkg.sv
// ----------------------------------------------------------------------------
// gxlit_pkg
// Types, the rule table and its lookup function shared by the transliterator.
// ----------------------------------------------------------------------------
package gxlit_pkg;

  localparam int WinDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_char;
    logic       end_out;
  } out_item_t;

  typedef struct packed {
    logic        is4;
    logic [31:0] g;
    logic [15:0] lat;
  } rule_t;

  // Decision of the front end: wait, apply a rule, or pass the front byte.
  typedef enum logic [1:0] {DEC_WAIT, DEC_RULE, DEC_PASS} dec_t;

  // Work handed to the back end: up to two letters, or only an end marker.
  typedef struct packed {
    logic [1:0]  nlet;
    logic [15:0] lat;
    logic        fin;
  } job_t;

  function automatic rule_t r4(logic [31:0] g, logic [15:0] l);
    rule_t r;
    r.is4 = 1'b1;
    r.g   = g;
    r.lat = l;
    return r;
  endfunction

  function automatic rule_t r2(logic [15:0] g, logic [15:0] l);
    rule_t r;
    r.is4 = 1'b0;
    r.g   = {g, 16'h0000};
    r.lat = l;
    return r;
  endfunction

  function automatic rule_t rule_at(logic [6:0] i);
    rule_t r;
    case (i)
      7'd0:   r = r4(32'hCE9FCEA5, "OU");
      7'd1:   r = r4(32'hCE9FCF85, "Ou");
      7'd2:   r = r4(32'hCEBFCF85, "ou");
      7'd3:   r = r4(32'hCE91CEA5, "AU");
      7'd4:   r = r4(32'hCE91CF85, "Au");
      7'd5:   r = r4(32'hCEB1CF85, "au");
      7'd6:   r = r4(32'hCE95CEA5, "EU");
      7'd7:   r = r4(32'hCE95CF85, "Eu");
      7'd8:   r = r4(32'hCEB5CF85, "eu");
      7'd9:   r = r4(32'hCE91CE99, "AI");
      7'd10:  r = r4(32'hCE91CEB9, "Ai");
      7'd11:  r = r4(32'hCEB1CEB9, "ai");
      7'd12:  r = r4(32'hCE95CE99, "EI");
      7'd13:  r = r4(32'hCE95CEB9, "Ei");
      7'd14:  r = r4(32'hCEB5CEB9, "ei");
      7'd15:  r = r4(32'hCE9FCE99, "OI");
      7'd16:  r = r4(32'hCE9FCEB9, "Oi");
      7'd17:  r = r4(32'hCEBFCEB9, "oi");
      7'd18:  r = r4(32'hCE9CCEA0, "MP");
      7'd19:  r = r4(32'hCE9CCF80, "Mp");
      7'd20:  r = r4(32'hCEBCCF80, "mp");
      7'd21:  r = r4(32'hCE9DCEA4, "NT");
      7'd22:  r = r4(32'hCE9DCF84, "Nt");
      7'd23:  r = r4(32'hCEBDCF84, "nt");
      7'd24:  r = r4(32'hCE93CE9A, "GK");
      7'd25:  r = r4(32'hCE93CEBA, "Gk");
      7'd26:  r = r4(32'hCEB3CEBA, "gk");
      7'd27:  r = r4(32'hCE93CE93, "GG");
      7'd28:  r = r4(32'hCE93CEB3, "Gg");
      7'd29:  r = r4(32'hCEB3CEB3, "gg");
      7'd30:  r = r4(32'hCEA4CEA3, "TS");
      7'd31:  r = r4(32'hCEA4CF83, "Ts");
      7'd32:  r = r4(32'hCF84CF83, "ts");
      7'd33:  r = r4(32'hCEA4CE96, "TZ");
      7'd34:  r = r4(32'hCEA4CEB6, "Tz");
      7'd35:  r = r4(32'hCF84CEB6, "tz");
      7'd36:  r = r2(16'hCE86, {8'h00, "A"});
      7'd37:  r = r2(16'hCEAC, {8'h00, "a"});
      7'd38:  r = r2(16'hCE88, {8'h00, "E"});
      7'd39:  r = r2(16'hCEAD, {8'h00, "e"});
      7'd40:  r = r2(16'hCE89, {8'h00, "I"});
      7'd41:  r = r2(16'hCEAE, {8'h00, "i"});
      7'd42:  r = r2(16'hCE8A, {8'h00, "I"});
      7'd43:  r = r2(16'hCEAF, {8'h00, "i"});
      7'd44:  r = r2(16'hCEAA, {8'h00, "I"});
      7'd45:  r = r2(16'hCF8A, {8'h00, "i"});
      7'd46:  r = r2(16'hCE90, {8'h00, "i"});
      7'd47:  r = r2(16'hCE8C, {8'h00, "O"});
      7'd48:  r = r2(16'hCF8C, {8'h00, "o"});
      7'd49:  r = r2(16'hCE8E, {8'h00, "Y"});
      7'd50:  r = r2(16'hCF8D, {8'h00, "y"});
      7'd51:  r = r2(16'hCEAB, {8'h00, "Y"});
      7'd52:  r = r2(16'hCF8B, {8'h00, "y"});
      7'd53:  r = r2(16'hCEB0, {8'h00, "y"});
      7'd54:  r = r2(16'hCE8F, {8'h00, "O"});
      7'd55:  r = r2(16'hCF8E, {8'h00, "o"});
      7'd56:  r = r2(16'hCE91, {8'h00, "A"});
      7'd57:  r = r2(16'hCEB1, {8'h00, "a"});
      7'd58:  r = r2(16'hCE92, {8'h00, "V"});
      7'd59:  r = r2(16'hCEB2, {8'h00, "v"});
      7'd60:  r = r2(16'hCE93, {8'h00, "G"});
      7'd61:  r = r2(16'hCEB3, {8'h00, "g"});
      7'd62:  r = r2(16'hCE94, {8'h00, "D"});
      7'd63:  r = r2(16'hCEB4, {8'h00, "d"});
      7'd64:  r = r2(16'hCE95, {8'h00, "E"});
      7'd65:  r = r2(16'hCEB5, {8'h00, "e"});
      7'd66:  r = r2(16'hCE96, {8'h00, "Z"});
      7'd67:  r = r2(16'hCEB6, {8'h00, "z"});
      7'd68:  r = r2(16'hCE97, {8'h00, "I"});
      7'd69:  r = r2(16'hCEB7, {8'h00, "i"});
      7'd70:  r = r2(16'hCE98, "Th");
      7'd71:  r = r2(16'hCEB8, "th");
      7'd72:  r = r2(16'hCE99, {8'h00, "I"});
      7'd73:  r = r2(16'hCEB9, {8'h00, "i"});
      7'd74:  r = r2(16'hCE9A, {8'h00, "K"});
      7'd75:  r = r2(16'hCEBA, {8'h00, "k"});
      7'd76:  r = r2(16'hCE9B, {8'h00, "L"});
      7'd77:  r = r2(16'hCEBB, {8'h00, "l"});
      7'd78:  r = r2(16'hCE9C, {8'h00, "M"});
      7'd79:  r = r2(16'hCEBC, {8'h00, "m"});
      7'd80:  r = r2(16'hCE9D, {8'h00, "N"});
      7'd81:  r = r2(16'hCEBD, {8'h00, "n"});
      7'd82:  r = r2(16'hCE9E, {8'h00, "X"});
      7'd83:  r = r2(16'hCEBE, {8'h00, "x"});
      7'd84:  r = r2(16'hCE9F, {8'h00, "O"});
      7'd85:  r = r2(16'hCEBF, {8'h00, "o"});
      7'd86:  r = r2(16'hCEA0, {8'h00, "P"});
      7'd87:  r = r2(16'hCF80, {8'h00, "p"});
      7'd88:  r = r2(16'hCEA1, {8'h00, "R"});
      7'd89:  r = r2(16'hCF81, {8'h00, "r"});
      7'd90:  r = r2(16'hCEA3, {8'h00, "S"});
      7'd91:  r = r2(16'hCF83, {8'h00, "s"});
      7'd92:  r = r2(16'hCF82, {8'h00, "s"});
      7'd93:  r = r2(16'hCEA4, {8'h00, "T"});
      7'd94:  r = r2(16'hCF84, {8'h00, "t"});
      7'd95:  r = r2(16'hCEA5, {8'h00, "Y"});
      7'd96:  r = r2(16'hCF85, {8'h00, "y"});
      7'd97:  r = r2(16'hCEA6, {8'h00, "F"});
      7'd98:  r = r2(16'hCF86, {8'h00, "f"});
      7'd99:  r = r2(16'hCEA7, "Ch");
      7'd100: r = r2(16'hCF87, "ch");
      7'd101: r = r2(16'hCEA8, "Ps");
      7'd102: r = r2(16'hCF88, "ps");
      7'd103: r = r2(16'hCEA9, {8'h00, "O"});
      7'd104: r = r2(16'hCF89, {8'h00, "o"});
      7'd105: r = r2(16'hCC81, 16'h0000);
      7'd106: r = r2(16'hCE84, 16'h0000);
      default: r = r2(16'h0000, 16'h0000);
    endcase
    return r;
  endfunction

  localparam int TabLen = 107;

endpackage

>>> rtl/gxlit_if.sv
// ----------------------------------------------------------------------------
// gxlit_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface gxlit_if #(
  parameter int W = 9
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gxlit_front.sv
// ----------------------------------------------------------------------------
// gxlit_front
// Window register and rule matcher. Each cycle, while the job queue has room, it
// takes one decision on the window: wait for more bytes, apply a rule, or pass
// the front byte, and hands the letters or end marker it makes to the job queue.
// ----------------------------------------------------------------------------
module gxlit_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gxlit_pkg::in_item_t in_item,
  output logic                job_valid,
  input  logic                job_ready,
  output gxlit_pkg::job_t     job
);
  import gxlit_pkg::*;

  logic [7:0] win_r [WinDepth];
  logic [7:0] win_nxt [WinDepth];
  logic [2:0] fill_r, fill_nxt;
  logic       fin_r, fin_nxt;
  logic       busy;
  dec_t       dec;
  logic       hit_is4;
  logic [15:0] hit_lat;
  logic [2:0] drop;

  // The window is busy while it holds a decidable run or a pending end.
  // An input byte is only taken when the matcher has nothing else to do.
  always_comb begin
    rule_t      r;
    logic [2:0] len;
    logic [31:0] w;
    logic       pre;
    logic       done;
    dec     = DEC_PASS;
    hit_is4 = 1'b0;
    hit_lat = '0;
    w       = {win_r[0], win_r[1], win_r[2], win_r[3]};
    done    = 1'b0;
    if (fill_r == 3'd0) begin
      dec  = DEC_WAIT;
      done = 1'b1;
    end
    for (int j = 0; j < TabLen; j++) begin
      r   = rule_at(7'(j));
      len = r.is4 ? 3'd4 : 3'd2;
      pre = 1'b1;
      for (int b = 0; b < WinDepth; b++) begin
        if (b < int'(fill_r) && b < int'(len) &&
            w[31-8*b -: 8] != r.g[31-8*b -: 8]) begin
          pre = 1'b0;
        end
      end
      if (!done && pre) begin
        if (fill_r >= len) begin
          dec     = DEC_RULE;
          hit_is4 = r.is4;
          hit_lat = r.lat;
          done    = 1'b1;
        end else if (!fin_r) begin
          dec  = DEC_WAIT;
          done = 1'b1;
        end
      end
    end
  end

  // Work is pending when a decision fires or a flushed end still owes its marker.
  assign busy     = (dec != DEC_WAIT) || fin_r;
  assign in_ready = !busy;

  always_comb begin
    job.fin  = 1'b0;
    job.lat  = '0;
    job.nlet = 2'd0;
    drop     = 3'd0;
    job_valid = 1'b0;
    case (dec)
      DEC_RULE: begin
        job_valid = 1'b1;
        job.lat   = hit_lat;
        job.nlet  = (hit_lat[15:8] != 8'h00) ? 2'd2 : ((hit_lat[7:0] != 8'h00) ? 2'd1 : 2'd0);
        drop      = hit_is4 ? 3'd4 : 3'd2;
      end
      DEC_PASS: begin
        job_valid = 1'b1;
        job.lat   = {8'h00, win_r[0]};
        job.nlet  = 2'd1;
        drop      = 3'd1;
      end
      DEC_WAIT: begin
        if (fin_r) begin
          job_valid = 1'b1;
          job.fin   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // A pass-through byte of value zero still counts as one letter.
  always_comb begin
    for (int i = 0; i < WinDepth; i++) win_nxt[i] = win_r[i];
    fill_nxt = fill_r;
    fin_nxt  = fin_r;
    if (job_valid && job_ready) begin
      if (job.fin) begin
        fin_nxt  = 1'b0;
        fill_nxt = 3'd0;
      end else begin
        for (int i = 0; i < WinDepth; i++) begin
          win_nxt[i] = (i + int'(drop) < WinDepth) ? win_r[i + int'(drop)] : 8'h00;
        end
        fill_nxt = fill_r - drop;
      end
    end else if (in_valid && in_ready) begin
      win_nxt[fill_r[1:0]] = in_item.in_byte;
      fill_nxt = fill_r + 3'd1;
      fin_nxt  = in_item.end_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
      fin_r  <= 1'b0;
      for (int i = 0; i < WinDepth; i++) win_r[i] <= 8'h00;
    end else begin
      fill_r <= fill_nxt;
      fin_r  <= fin_nxt;
      for (int i = 0; i < WinDepth; i++) win_r[i] <= win_nxt[i];
    end
  end

endmodule

>>> rtl/gxlit_queue.sv
// ----------------------------------------------------------------------------
// gxlit_queue
// Two-entry job queue between the matcher and the output sequencer.
// ----------------------------------------------------------------------------
module gxlit_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  gxlit_pkg::job_t   wr_job,
  output logic              rd_valid,
  input  logic              rd_ready,
  output gxlit_pkg::job_t   rd_job
);
  import gxlit_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/gxlit_back.sv
// ----------------------------------------------------------------------------
// gxlit_back
// Output sequencer. Unrolls each job into zero, one or two letter transfers
// or one end marker, through a registered output stage.
// ----------------------------------------------------------------------------
module gxlit_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  gxlit_pkg::job_t      job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gxlit_pkg::out_item_t out_item
);
  import gxlit_pkg::*;

  logic      step_r, step_nxt;
  logic      ov_r, ov_nxt;
  out_item_t oi_r, oi_nxt;
  logic      slot_free;

  assign out_valid = ov_r;
  assign out_item  = oi_r;
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    step_nxt  = step_r;
    ov_nxt    = ov_r && !out_ready;
    oi_nxt    = oi_r;
    job_ready = 1'b0;
    if (job_valid) begin
      if (job.fin) begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          oi_nxt    = '{out_byte: 8'h00, no_char: 1'b1, end_out: 1'b1};
          job_ready = 1'b1;
        end
      end else if (job.nlet == 2'd0) begin
        job_ready = 1'b1;
      end else if (slot_free) begin
        ov_nxt = 1'b1;
        if (job.nlet == 2'd2 && !step_r) begin
          oi_nxt   = '{out_byte: job.lat[15:8], no_char: 1'b0, end_out: 1'b0};
          step_nxt = 1'b1;
        end else begin
          oi_nxt    = '{out_byte: job.lat[7:0], no_char: 1'b0, end_out: 1'b0};
          step_nxt  = 1'b0;
          job_ready = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
    if (!rst_n) begin
      step_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

>>> rtl/greek_utf8_to_latin_transliterator_core.sv
// ----------------------------------------------------------------------------
// greek_utf8_to_latin_transliterator_core
// Greek UTF-8 to Latin letter transliterator, top level.
// ----------------------------------------------------------------------------
// Usage: UTF-8 text enters one byte per transfer on the in_ channel, with
// in_end_text set on the last byte. Latin bytes leave on the out_ channel;
// after the last byte of a text one transfer with out_no_char and out_end_out
// set marks the end. Both channels are valid/ready.
// The matcher holds a four-byte window and takes one decision per cycle
// against the rule table while the job queue has room; an input byte is
// taken only in a cycle with no decision to make. The output sequencer
// sends one letter per cycle while the receiver is ready. An input byte
// reaches the output through the window register, the job queue and the
// output register. A two-entry job queue lets the matcher go on while the
// receiver stalls; when it fills, the matcher holds its pending decision,
// so in_ready stays low. Reset empties the window, the queue and the
// output register; nothing else needs clearing.
// ----------------------------------------------------------------------------
module greek_utf8_to_latin_transliterator_core (
  input  logic clk,
  input  logic rst_n,
  gxlit_if.sink   in_ch,
  gxlit_if.source out_ch
);
  import gxlit_pkg::*;

  logic      fj_valid, fj_ready, bj_valid, bj_ready;
  job_t      fj, bj;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item = in_ch.data;
  assign out_ch.data = out_item;

  gxlit_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_item,
    .job_valid (fj_valid), .job_ready (fj_ready), .job (fj)
  );

  gxlit_queue u_queue (
    .clk, .rst_n,
    .wr_valid (fj_valid), .wr_ready (fj_ready), .wr_job (fj),
    .rd_valid (bj_valid), .rd_ready (bj_ready), .rd_job (bj)
  );

  gxlit_back u_back (
    .clk, .rst_n,
    .job_valid (bj_valid), .job_ready (bj_ready), .job (bj),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_item
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Greek to Latin transliterator core: a short
// table of directed bytes, then random Greek, ASCII and malformed text, each
// result transfer checked in order against a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
  import gxlit_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         has_exp;
    out_item_t  exp_first;
  } stim_t;

  logic clk;
  logic rst_n;
  gxlit_if #(.W(9))  in_if ();
  gxlit_if #(.W(10)) out_if ();

  greek_utf8_to_latin_transliterator_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // Rule table of the transliterator, in priority order.
  int          rule_len[$];
  logic [31:0] rule_seq[$];
  logic [15:0] rule_lat[$];

  logic [7:0]  win[WinDepth];
  int          win_fill;
  out_item_t   latin_q[$];
  stim_t       stim_q[$];
  int          errors;
  int          cycles;
  int          n_out;
  int          n_texts;
  bit          rx_idle_off;

  task automatic add4(logic [31:0] g, logic [15:0] l);
    rule_len.push_back(4); rule_seq.push_back(g); rule_lat.push_back(l);
  endtask

  task automatic add2(logic [15:0] g, logic [15:0] l);
    rule_len.push_back(2); rule_seq.push_back({g, 16'h0000}); rule_lat.push_back(l);
  endtask

  task automatic build_rules();
    add4(32'hCE9FCEA5, "OU"); add4(32'hCE9FCF85, "Ou"); add4(32'hCEBFCF85, "ou");
    add4(32'hCE91CEA5, "AU"); add4(32'hCE91CF85, "Au"); add4(32'hCEB1CF85, "au");
    add4(32'hCE95CEA5, "EU"); add4(32'hCE95CF85, "Eu"); add4(32'hCEB5CF85, "eu");
    add4(32'hCE91CE99, "AI"); add4(32'hCE91CEB9, "Ai"); add4(32'hCEB1CEB9, "ai");
    add4(32'hCE95CE99, "EI"); add4(32'hCE95CEB9, "Ei"); add4(32'hCEB5CEB9, "ei");
    add4(32'hCE9FCE99, "OI"); add4(32'hCE9FCEB9, "Oi"); add4(32'hCEBFCEB9, "oi");
    add4(32'hCE9CCEA0, "MP"); add4(32'hCE9CCF80, "Mp"); add4(32'hCEBCCF80, "mp");
    add4(32'hCE9DCEA4, "NT"); add4(32'hCE9DCF84, "Nt"); add4(32'hCEBDCF84, "nt");
    add4(32'hCE93CE9A, "GK"); add4(32'hCE93CEBA, "Gk"); add4(32'hCEB3CEBA, "gk");
    add4(32'hCE93CE93, "GG"); add4(32'hCE93CEB3, "Gg"); add4(32'hCEB3CEB3, "gg");
    add4(32'hCEA4CEA3, "TS"); add4(32'hCEA4CF83, "Ts"); add4(32'hCF84CF83, "ts");
    add4(32'hCEA4CE96, "TZ"); add4(32'hCEA4CEB6, "Tz"); add4(32'hCF84CEB6, "tz");
    add2(16'hCE86, "A"); add2(16'hCEAC, "a"); add2(16'hCE88, "E"); add2(16'hCEAD, "e");
    add2(16'hCE89, "I"); add2(16'hCEAE, "i"); add2(16'hCE8A, "I"); add2(16'hCEAF, "i");
    add2(16'hCEAA, "I"); add2(16'hCF8A, "i"); add2(16'hCE90, "i");
    add2(16'hCE8C, "O"); add2(16'hCF8C, "o"); add2(16'hCE8E, "Y"); add2(16'hCF8D, "y");
    add2(16'hCEAB, "Y"); add2(16'hCF8B, "y"); add2(16'hCEB0, "y");
    add2(16'hCE8F, "O"); add2(16'hCF8E, "o");
    add2(16'hCE91, "A"); add2(16'hCEB1, "a"); add2(16'hCE92, "V"); add2(16'hCEB2, "v");
    add2(16'hCE93, "G"); add2(16'hCEB3, "g"); add2(16'hCE94, "D"); add2(16'hCEB4, "d");
    add2(16'hCE95, "E"); add2(16'hCEB5, "e"); add2(16'hCE96, "Z"); add2(16'hCEB6, "z");
    add2(16'hCE97, "I"); add2(16'hCEB7, "i"); add2(16'hCE98, "Th"); add2(16'hCEB8, "th");
    add2(16'hCE99, "I"); add2(16'hCEB9, "i"); add2(16'hCE9A, "K"); add2(16'hCEBA, "k");
    add2(16'hCE9B, "L"); add2(16'hCEBB, "l"); add2(16'hCE9C, "M"); add2(16'hCEBC, "m");
    add2(16'hCE9D, "N"); add2(16'hCEBD, "n"); add2(16'hCE9E, "X"); add2(16'hCEBE, "x");
    add2(16'hCE9F, "O"); add2(16'hCEBF, "o"); add2(16'hCEA0, "P"); add2(16'hCF80, "p");
    add2(16'hCEA1, "R"); add2(16'hCF81, "r"); add2(16'hCEA3, "S"); add2(16'hCF83, "s");
    add2(16'hCF82, "s"); add2(16'hCEA4, "T"); add2(16'hCF84, "t");
    add2(16'hCEA5, "Y"); add2(16'hCF85, "y"); add2(16'hCEA6, "F"); add2(16'hCF86, "f");
    add2(16'hCEA7, "Ch"); add2(16'hCF87, "ch"); add2(16'hCEA8, "Ps"); add2(16'hCF88, "ps");
    add2(16'hCEA9, "O"); add2(16'hCF89, "o");
    add2(16'hCC81, 16'h0000); add2(16'hCE84, 16'h0000);
  endtask

  function automatic bit seq_match(int j, int n);
    bit ok;
    ok = 1'b1;
    for (int k = 0; k < n; k++)
      if (win[k] != rule_seq[j][31-8*k -: 8]) ok = 1'b0;
    return ok;
  endfunction

  // Wait for more bytes, apply rule which, or pass the front byte.
  function automatic dec_t pick_rule(bit fin, output int which);
    which = 0;
    if (win_fill == 0) return DEC_WAIT;
    for (int j = 0; j < rule_len.size(); j++) begin
      if (win_fill >= rule_len[j]) begin
        if (seq_match(j, rule_len[j])) begin
          which = j;
          return DEC_RULE;
        end
      end else if (!fin && seq_match(j, win_fill)) begin
        return DEC_WAIT;
      end
    end
    return DEC_PASS;
  endfunction

  function automatic out_item_t letter(logic [7:0] b, logic nc, logic eo);
    out_item_t r;
    r.out_byte = b;
    r.no_char  = nc;
    r.end_out  = eo;
    return r;
  endfunction

  task automatic drop_front(int k);
    for (int i = 0; i < WinDepth; i++) win[i] = (i + k < WinDepth) ? win[i+k] : 8'h00;
    win_fill -= k;
  endtask

  task automatic transliterate(logic [7:0] b, logic fin, output out_item_t first,
                               output int made);
    int which;
    dec_t dec;
    made = 0;
    first = letter(8'h00, 1'b0, 1'b0);
    win[win_fill] = b;
    win_fill++;
    forever begin
      dec = pick_rule(fin, which);
      if (dec == DEC_WAIT) break;
      if (dec == DEC_RULE) begin
        if (rule_lat[which][15:8] != 8'h00) begin
          if (made == 0) first = letter(rule_lat[which][15:8], 1'b0, 1'b0);
          latin_q.push_back(letter(rule_lat[which][15:8], 1'b0, 1'b0));
          made++;
        end
        if (rule_lat[which][7:0] != 8'h00) begin
          if (made == 0) first = letter(rule_lat[which][7:0], 1'b0, 1'b0);
          latin_q.push_back(letter(rule_lat[which][7:0], 1'b0, 1'b0));
          made++;
        end
        drop_front(rule_len[which]);
      end else begin
        if (made == 0) first = letter(win[0], 1'b0, 1'b0);
        latin_q.push_back(letter(win[0], 1'b0, 1'b0));
        made++;
        drop_front(1);
      end
    end
    if (fin) begin
      for (int i = 0; i < WinDepth; i++) win[i] = 8'h00;
      win_fill = 0;
      if (made == 0) first = letter(8'h00, 1'b1, 1'b1);
      latin_q.push_back(letter(8'h00, 1'b1, 1'b1));
      made++;
    end
  endtask

  task automatic report_mismatch(string what, logic [9:0] got, logic [9:0] want);
    $display("mismatch at cycle %0d: %s got %03h expected %03h", cycles, what, got, want);
    errors++;
  endtask

  task automatic add_row(logic [7:0] b, logic fin, bit he, out_item_t e);
    stim_t s;
    s.b = b; s.fin = fin; s.has_exp = he; s.exp_first = e;
    stim_q.push_back(s);
  endtask

  task automatic add_plain(logic [7:0] b, logic fin);
    add_row(b, fin, 1'b0, letter(8'h00, 1'b0, 1'b0));
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("timeout with %0d results still expected", latin_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_out <= n_out + 1;
      if (latin_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_if.data, 10'h000);
      end else if (out_if.data != latin_q[0]) begin
        report_mismatch("result", out_if.data, latin_q[0]);
        void'(latin_q.pop_front());
      end else begin
        void'(latin_q.pop_front());
      end
    end
  end

  // Receiver: random stalls per transfer, one long hold-off, quiet stretches.
  initial begin
    int stall;
    int taken;
    out_if.ready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 60) stall = 500;
      else if (rx_idle_off) stall = 0;
      else stall = $urandom_range(0, 19);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int gap;
    int idx;
    int made;
    int kind;
    int n_rand;
    out_item_t first;
    stim_t s;

    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_n <= 1'b0;
    errors = 0;
    cycles = 0;
    n_out = 0;
    n_texts = 0;
    rx_idle_off = 1'b0;
    win_fill = 0;
    for (int i = 0; i < WinDepth; i++) win[i] = 8'h00;
    build_rules();

    // Directed rows: extremes, digraphs, two-letter singles, tonos marks,
    // waiting prefixes cut by the end flag, and malformed lead bytes.
    add_row(8'h00, 1'b0, 1'b1, letter(8'h00, 1'b0, 1'b0));
    add_row(8'hFF, 1'b1, 1'b1, letter(8'hFF, 1'b0, 1'b0));
    add_plain(8'hCE, 1'b0); add_plain(8'h9F, 1'b0); add_plain(8'hCE, 1'b0);
    add_row(8'hA5, 1'b0, 1'b1, letter("O", 1'b0, 1'b0));
    add_plain(8'hCE, 1'b0);
    add_row(8'h98, 1'b0, 1'b1, letter("T", 1'b0, 1'b0));
    add_plain(8'hCE, 1'b0); add_plain(8'h84, 1'b0);
    add_plain(8'hCC, 1'b0); add_plain(8'h81, 1'b0);
    add_plain(8'hCE, 1'b0); add_plain(8'hA7, 1'b0);
    add_plain(8'hCE, 1'b0); add_plain(8'h91, 1'b1);
    add_row(8'hCE, 1'b1, 1'b1, letter(8'hCE, 1'b0, 1'b0));
    add_plain(8'hCF, 1'b0); add_plain(8'h84, 1'b0); add_plain(8'hCF, 1'b1);
    add_row(8'h41, 1'b1, 1'b1, letter(8'h41, 1'b0, 1'b0));
    add_plain(8'hCE, 1'b0); add_plain(8'h7F, 1'b0);
    add_plain(8'h80, 1'b1);

    // Random text: mostly well-formed Greek with ASCII, stray and cut bytes.
    n_rand = 0;
    while (n_rand < 470) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        idx = $urandom_range(0, rule_len.size() - 1);
        for (int k = 0; k < rule_len[idx]; k++) begin
          add_plain(rule_seq[idx][31-8*k -: 8], 1'b0);
          n_rand++;
        end
      end else if (kind < 75) begin
        add_plain(8'($urandom_range(32, 126)), 1'b0);
        n_rand++;
      end else if (kind < 90) begin
        add_plain(8'($urandom_range(0, 255)), 1'b0);
        n_rand++;
      end else begin
        add_plain($urandom_range(0, 1) ? 8'hCE : 8'hCF, 1'b0);
        n_rand++;
      end
      if ($urandom_range(0, 24) == 0) stim_q[stim_q.size()-1].fin = 1'b1;
    end
    stim_q[stim_q.size()-1].fin = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim_q.size(); i++) begin
      s = stim_q[i];
      rx_idle_off = ((i / 80) % 3) == 2;
      gap = rx_idle_off ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_if.valid <= 1'b1;
      in_if.data  <= {s.b, s.fin};
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      transliterate(s.b, s.fin, first, made);
      if (s.fin) n_texts++;
      if (s.has_exp && (made == 0 || first != s.exp_first))
        report_mismatch("directed first result", first, s.exp_first);
    end
    in_if.valid <= 1'b0;
    rx_idle_off = 1'b0;

    while (latin_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d input bytes in %0d texts, %0d result transfers checked",
             stim_q.size(), n_texts, n_out);
    $display("directed rows, random Greek text, long output stall exercised");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
